FILE: rtl/sha1h_pkg.sv
// Shared types and constants for the SHA-1 byte stream hasher.
// Used by the controller, the datapath and the top level; no dependencies.
package sha1h_pkg;

    // Operation codes carried in the input tuser
    localparam logic OP_ABSORB = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    // Round count and block positions
    localparam int unsigned ROUNDS     = 80;
    localparam logic [6:0]  LAST_ROUND = 7'(ROUNDS - 1);
    localparam logic [5:0]  LAST_POS   = 6'd63;   // last byte of a 64-byte block
    localparam logic [5:0]  PAD_POS    = 6'd56;   // byte where the length field starts
    localparam logic [2:0]  LAST_LEN   = 3'd7;    // last byte of the length field
    localparam logic [2:0]  LAST_WORD  = 3'd4;    // fifth digest word
    localparam int unsigned NUM_WORDS  = 5;

    // Initial chaining values
    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hEFCDAB89;
    localparam logic [31:0] IV2 = 32'h98BADCFE;
    localparam logic [31:0] IV3 = 32'h10325476;
    localparam logic [31:0] IV4 = 32'hC3D2E1F0;

    // Round constants
    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD_ONE,
        ST_PAD_ZERO,
        ST_PAD_LEN,
        ST_ROUND,
        ST_FOLD,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        PH_CHOOSE,
        PH_PARITY1,
        PH_MAJORITY,
        PH_PARITY2
    } phase_t;

    typedef enum logic [1:0] {
        BSEL_DATA,
        BSEL_PAD,
        BSEL_ZERO,
        BSEL_LEN
    } byte_sel_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic      absorb;
        byte_sel_t byte_sel;
        logic      latch_len;
        logic      load_vars;
        logic      round;
        phase_t    phase;
        logic      fold;
        logic      init;
        logic [2:0] out_idx;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic pos_last;   // next byte completes the block
        logic pad_done;   // length field is next
    } status_t;

endpackage

FILE: rtl/sha1h_ctrl.sv
// Sequencer for the SHA-1 hasher: handshakes, padding steps, round count, digest output.
// Depends on sha1h_pkg.
module sha1h_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic                op,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic                last_word,
    input  sha1h_pkg::status_t  status,
    output sha1h_pkg::cmd_t     cmd
);
    import sha1h_pkg::*;

    state_t     state_reg, state_next;
    state_t     ret_reg, ret_next;
    logic [6:0] cnt_reg, cnt_next;

    // Hold state, return point and counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ret_reg   <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    if (op == OP_FINISH)
                    begin
                        state_next = ST_PAD_ONE;
                    end
                    else if (status.pos_last)
                    begin
                        state_next = ST_ROUND;
                        ret_next   = ST_IDLE;
                        cnt_next   = '0;
                    end
                end
            end
            ST_PAD_ONE:
            begin
                state_next = status.pos_last ? ST_ROUND : ST_PAD_ZERO;
                ret_next   = ST_PAD_ZERO;
                cnt_next   = '0;
            end
            ST_PAD_ZERO:
            begin
                cnt_next = '0;
                if (status.pad_done)
                begin
                    state_next = ST_PAD_LEN;
                end
                else if (status.pos_last)
                begin
                    state_next = ST_ROUND;
                    ret_next   = ST_PAD_ZERO;
                end
            end
            ST_PAD_LEN:
            begin
                if (cnt_reg[2:0] == LAST_LEN)
                begin
                    state_next = ST_ROUND;
                    ret_next   = ST_OUT;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 7'd1;
                end
            end
            ST_ROUND:
            begin
                if (cnt_reg == LAST_ROUND)
                begin
                    state_next = ST_FOLD;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 7'd1;
                end
            end
            ST_FOLD:
            begin
                state_next = ret_reg;
                cnt_next   = '0;
            end
            ST_OUT:
            begin
                if (m_axis_tready)
                begin
                    if (cnt_reg[2:0] == LAST_WORD)
                    begin
                        state_next = ST_IDLE;
                        cnt_next   = '0;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 7'd1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                cnt_next   = '0;
            end
        endcase
    end

    // Outputs and datapath commands
    always_comb
    begin
        cmd           = '0;
        cmd.byte_sel  = BSEL_DATA;
        cmd.phase     = PH_CHOOSE;
        cmd.out_idx   = cnt_reg[2:0];
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        last_word     = (cnt_reg[2:0] == LAST_WORD);
        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    if (op == OP_FINISH)
                    begin
                        cmd.latch_len = 1'b1;
                    end
                    else
                    begin
                        cmd.absorb    = 1'b1;
                        cmd.load_vars = status.pos_last;
                    end
                end
            end
            ST_PAD_ONE:
            begin
                cmd.absorb    = 1'b1;
                cmd.byte_sel  = BSEL_PAD;
                cmd.load_vars = status.pos_last;
            end
            ST_PAD_ZERO:
            begin
                if (!status.pad_done)
                begin
                    cmd.absorb    = 1'b1;
                    cmd.byte_sel  = BSEL_ZERO;
                    cmd.load_vars = status.pos_last;
                end
            end
            ST_PAD_LEN:
            begin
                cmd.absorb    = 1'b1;
                cmd.byte_sel  = BSEL_LEN;
                cmd.load_vars = status.pos_last;
            end
            ST_ROUND:
            begin
                cmd.round = 1'b1;
                if (cnt_reg < 7'd20)
                    cmd.phase = PH_CHOOSE;
                else if (cnt_reg < 7'd40)
                    cmd.phase = PH_PARITY1;
                else if (cnt_reg < 7'd60)
                    cmd.phase = PH_MAJORITY;
                else
                    cmd.phase = PH_PARITY2;
            end
            ST_FOLD:
            begin
                cmd.fold = 1'b1;
            end
            ST_OUT:
            begin
                m_axis_tvalid = 1'b1;
                cmd.init      = m_axis_tready && (cnt_reg[2:0] == LAST_WORD);
            end
            default:
            begin
                cmd.absorb = 1'b0;
            end
        endcase
    end

endmodule

FILE: rtl/sha1h_dp.sv
// Datapath for the SHA-1 hasher: block shift line, bit counter, round unit, chaining words.
// Depends on sha1h_pkg.
module sha1h_dp
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [7:0]         data_byte,
    input  sha1h_pkg::cmd_t    cmd,
    output sha1h_pkg::status_t status,
    output logic [31:0]        digest_word
);
    import sha1h_pkg::*;

    logic [31:0]  chain_reg [NUM_WORDS];
    logic [31:0]  chain_next [NUM_WORDS];
    logic [63:0]  bitlen_reg, bitlen_next;
    logic [63:0]  len_reg, len_next;
    logic [511:0] block_reg, block_next;
    logic [31:0]  a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0]  a_next, b_next, c_next, d_next, e_next;

    logic [7:0]  in_byte;
    logic [31:0] w_cur, w_new, w_mix, f_val, k_val, tmp;
    logic [5:0]  pos;

    assign pos             = bitlen_reg[8:3];
    assign status.pos_last = (pos == LAST_POS);
    assign status.pad_done = (pos == PAD_POS);

    // Byte to absorb
    always_comb
    begin
        case (cmd.byte_sel)
            BSEL_DATA: in_byte = data_byte;
            BSEL_PAD:  in_byte = PAD_BYTE;
            BSEL_ZERO: in_byte = 8'h00;
            BSEL_LEN:  in_byte = len_reg[63:56];
            default:   in_byte = 8'h00;
        endcase
    end

    // Schedule window: word 0 is the current round word, word 15 the newest
    assign w_cur = block_reg[511:480];
    assign w_mix = block_reg[95:64] ^ block_reg[255:224] ^ block_reg[447:416] ^ w_cur;
    assign w_new = {w_mix[30:0], w_mix[31]};

    // Round function and constant
    always_comb
    begin
        case (cmd.phase)
            PH_CHOOSE:
            begin
                f_val = (b_reg & c_reg) | (~b_reg & d_reg);
                k_val = K0;
            end
            PH_PARITY1:
            begin
                f_val = b_reg ^ c_reg ^ d_reg;
                k_val = K1;
            end
            PH_MAJORITY:
            begin
                f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
                k_val = K2;
            end
            PH_PARITY2:
            begin
                f_val = b_reg ^ c_reg ^ d_reg;
                k_val = K3;
            end
            default:
            begin
                f_val = '0;
                k_val = '0;
            end
        endcase
    end

    assign tmp = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + k_val + w_cur;

    // Next values of all datapath registers
    always_comb
    begin
        bitlen_next = bitlen_reg;
        len_next    = len_reg;
        block_next  = block_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        c_next      = c_reg;
        d_next      = d_reg;
        e_next      = e_reg;
        for (int i = 0; i < NUM_WORDS; i++)
        begin
            chain_next[i] = chain_reg[i];
        end

        if (cmd.latch_len)
        begin
            len_next = bitlen_reg;
        end

        // Shift the byte in and count its bits
        if (cmd.absorb)
        begin
            block_next  = {block_reg[503:0], in_byte};
            bitlen_next = bitlen_reg + 64'd8;
            if (cmd.byte_sel == BSEL_LEN)
            begin
                len_next = {len_reg[55:0], 8'h00};
            end
        end

        // Start a compression from the chaining words
        if (cmd.load_vars)
        begin
            a_next = chain_reg[0];
            b_next = chain_reg[1];
            c_next = chain_reg[2];
            d_next = chain_reg[3];
            e_next = chain_reg[4];
        end

        // One round; advance the schedule window
        if (cmd.round)
        begin
            a_next     = tmp;
            b_next     = a_reg;
            c_next     = {b_reg[1:0], b_reg[31:2]};
            d_next     = c_reg;
            e_next     = d_reg;
            block_next = {block_reg[479:0], w_new};
        end

        // Add the working variables into the chaining words
        if (cmd.fold)
        begin
            chain_next[0] = chain_reg[0] + a_reg;
            chain_next[1] = chain_reg[1] + b_reg;
            chain_next[2] = chain_reg[2] + c_reg;
            chain_next[3] = chain_reg[3] + d_reg;
            chain_next[4] = chain_reg[4] + e_reg;
        end

        // Return to the initial state after the digest is out
        if (cmd.init)
        begin
            chain_next[0] = IV0;
            chain_next[1] = IV1;
            chain_next[2] = IV2;
            chain_next[3] = IV3;
            chain_next[4] = IV4;
            bitlen_next   = '0;
        end
    end

    // Chaining words and bit counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg[0] <= IV0;
            chain_reg[1] <= IV1;
            chain_reg[2] <= IV2;
            chain_reg[3] <= IV3;
            chain_reg[4] <= IV4;
            bitlen_reg   <= '0;
        end
        else
        begin
            for (int i = 0; i < NUM_WORDS; i++)
            begin
                chain_reg[i] <= chain_next[i];
            end
            bitlen_reg <= bitlen_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        len_reg   <= len_next;
        block_reg <= block_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        c_reg     <= c_next;
        d_reg     <= d_next;
        e_reg     <= e_next;
    end

    // Select the digest word on output
    always_comb
    begin
        case (cmd.out_idx)
            3'd0:    digest_word = chain_reg[0];
            3'd1:    digest_word = chain_reg[1];
            3'd2:    digest_word = chain_reg[2];
            3'd3:    digest_word = chain_reg[3];
            3'd4:    digest_word = chain_reg[4];
            default: digest_word = '0;
        endcase
    end

endmodule

FILE: rtl/sha1_byte_stream_hasher.sv
// SHA-1 byte stream hasher: one item per message byte, a finish item emits five digest words.
// Each byte is absorbed in the idle state; the byte that fills a block adds 80 rounds and one fold,
// so a long message is paced by the single round unit, and no byte is taken until the fold is done.
// Finish: latch the length, absorb the pad bytes, step to the length field, absorb it,
// run one or two compressions, then send five output items, one per cycle while m_axis_tready is high.
// Reset (rst_n, asynchronous, active low) loads the initial chaining words and clears length.
module sha1_byte_stream_hasher
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,    // [7:0] data_byte
    input  logic        s_axis_tuser,    // [0] op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,    // [31:0] digest_word, [34:32] word_index, [39:35] zero
    output logic        m_axis_tlast     // last_word
);
    import sha1h_pkg::*;

    cmd_t        cmd;
    status_t     status;
    logic [31:0] digest_word;

    sha1h_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .op            (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .last_word     (m_axis_tlast),
        .status        (status),
        .cmd           (cmd)
    );

    sha1h_dp u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .data_byte   (s_axis_tdata),
        .cmd         (cmd),
        .status      (status),
        .digest_word (digest_word)
    );

    // Pack the output item
    assign m_axis_tdata = {5'b00000, cmd.out_idx, digest_word};

endmodule

FILE: dv/sha1_digest_checker.sv
// Checker for the SHA-1 byte stream hasher: watches both stream channels, predicts digests.
// Depends on sha1h_pkg for operation codes, initial chaining words and round constants.
`timescale 1ns / 100ps

module sha1_digest_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,    // [7:0] data_byte
    input  logic        s_axis_tuser,    // [0] op
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [39:0] m_axis_tdata,    // [31:0] digest_word, [34:32] word_index, [39:35] zero
    input  logic        m_axis_tlast,    // last_word
    output int          fail_count,
    output int          words_checked,
    output int          pending
);
    import sha1h_pkg::*;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_word_t;

    // Predicted hash state
    logic [31:0] chain[5];
    logic [31:0] blk[16];
    logic [63:0] msg_bits;

    digest_word_t digest_due[$];
    digest_word_t got_word;
    digest_word_t due_word;

    function automatic logic [31:0] rotl32(input logic [31:0] v, input int unsigned n);
        return (v << n) | (v >> (32 - n));
    endfunction

    task automatic clear_hash_state();
        chain[0] = IV0;
        chain[1] = IV1;
        chain[2] = IV2;
        chain[3] = IV3;
        chain[4] = IV4;
        msg_bits = '0;
    endtask

    // Run the 80 rounds over the block store and fold into the chaining words
    task automatic sha1_compress();
        logic [31:0] a, b, c, d, e, f, k, w, t_sum;
        a = chain[0];
        b = chain[1];
        c = chain[2];
        d = chain[3];
        e = chain[4];
        for (int t = 0; t < ROUNDS; t++)
        begin
            // expand the schedule in place; the 4-bit index wraps over the 16 words
            if (t >= 16)
            begin
                w = blk[4'(t + 13)] ^ blk[4'(t + 8)] ^ blk[4'(t + 2)] ^ blk[4'(t)];
                blk[4'(t)] = rotl32(w, 1);
            end
            w = blk[4'(t)];
            if (t < 20)
            begin
                f = (b & c) | (~b & d);
                k = K0;
            end
            else if (t < 40)
            begin
                f = b ^ c ^ d;
                k = K1;
            end
            else if (t < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = K2;
            end
            else
            begin
                f = b ^ c ^ d;
                k = K3;
            end
            t_sum = rotl32(a, 5) + f + e + k + w;
            e = d;
            d = c;
            c = rotl32(b, 30);
            b = a;
            a = t_sum;
        end
        chain[0] += a;
        chain[1] += b;
        chain[2] += c;
        chain[3] += d;
        chain[4] += e;
    endtask

    // Pack one byte big-endian into the block store; compress when the block fills
    task automatic absorb_octet(input logic [7:0] octet);
        logic [5:0] pos;
        logic [3:0] wi;
        int unsigned sh;
        pos = msg_bits[8:3];
        wi  = pos[5:2];
        sh  = (3 - pos[1:0]) * 8;
        if (pos[1:0] == 2'd0)
            blk[wi] = {24'h0, octet} << sh;
        else
            blk[wi] |= {24'h0, octet} << sh;
        msg_bits += 64'd8;
        if (pos == LAST_POS)
            sha1_compress();
    endtask

    // Pad, append the bit length, queue the five digest words, start over
    task automatic finish_message();
        logic [63:0] len;
        digest_word_t dw;
        len = msg_bits;
        absorb_octet(PAD_BYTE);
        while (msg_bits[8:3] != PAD_POS)
            absorb_octet(8'h00);
        for (int i = 0; i < 8; i++)
            absorb_octet(len[(7 - i) * 8 +: 8]);
        for (int i = 0; i < NUM_WORDS; i++)
        begin
            dw.word  = chain[3'(i)];
            dw.index = 3'(i);
            dw.last  = (3'(i) == LAST_WORD);
            digest_due.push_back(dw);
        end
        clear_hash_state();
    endtask

    // Check results first, then advance the prediction with the accepted input item
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            clear_hash_state();
            digest_due.delete();
            pending <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got_word.word  = m_axis_tdata[31:0];
                got_word.index = m_axis_tdata[34:32];
                got_word.last  = m_axis_tlast;
                if (digest_due.size() == 0)
                begin
                    $error("unexpected digest_word %h (word_index %0d)",
                           got_word.word, got_word.index);
                    fail_count++;
                end
                else
                begin
                    due_word = digest_due.pop_front();
                    words_checked++;
                    if (got_word.word !== due_word.word)
                    begin
                        $error("digest_word mismatch: expected %h, got %h",
                               due_word.word, got_word.word);
                        fail_count++;
                    end
                    if (got_word.index !== due_word.index)
                    begin
                        $error("word_index mismatch: expected %0d, got %0d",
                               due_word.index, got_word.index);
                        fail_count++;
                    end
                    if (got_word.last !== due_word.last)
                    begin
                        $error("last_word mismatch: expected %0b, got %0b",
                               due_word.last, got_word.last);
                        fail_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (s_axis_tuser == OP_FINISH)
                    finish_message();
                else
                    absorb_octet(s_axis_tdata);
            end
            pending <= digest_due.size();
        end
    end

endmodule

FILE: dv/testbench.sv
// Top of the SHA-1 byte stream hasher testbench: clock, reset, stimulus, back-pressure, verdict.
// Depends on sha1h_pkg, the hasher RTL and the sha1_digest_checker module.
`timescale 1ns / 100ps

module testbench;
    import sha1h_pkg::*;

    localparam int ITEM_TARGET    = 170;
    localparam int LONG_HOLD      = 400;
    localparam int HOLD_AT_WORD   = 10;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 300;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;     // [7:0] data_byte
    logic        s_axis_tuser = OP_ABSORB; // [0] op
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;             // [31:0] digest_word, [34:32] word_index
    logic        m_axis_tlast;             // last_word

    int fail_count;
    int words_checked;
    int pending;

    int  items_sent = 0;
    int  messages_sent = 0;
    int  idle_cycles = 0;
    bit  tx_burst = 1'b0;
    logic [7:0] message_q[$];

    sha1_byte_stream_hasher dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    sha1_digest_checker u_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .fail_count    (fail_count),
        .words_checked (words_checked),
        .pending       (pending)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Offer one item after a random gap and hold it until accepted
    task automatic send_item(input logic op, input logic [7:0] octet);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= octet;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        items_sent++;
    endtask

    // Absorb every byte of message_q, then finish with a junk byte in the ignored data field
    task automatic send_message(input logic [7:0] finish_junk);
        foreach (message_q[i])
            send_item(OP_ABSORB, message_q[i]);
        send_item(OP_FINISH, finish_junk);
        messages_sent++;
    endtask

    // Stop offering and wait until every predicted digest word has been seen
    task automatic drain_digests();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic fill_random(input int len);
        message_q.delete();
        repeat (len) message_q.push_back(8'($urandom_range(0, 255)));
    endtask

    // Stimulus
    initial
    begin
        int len;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty message, a short text, extreme bytes, junk on the finish item
        message_q.delete();
        send_message(8'h00);
        message_q = '{8'h61, 8'h62, 8'h63};
        send_message(8'h00);
        message_q = '{8'hFF};
        send_message(8'h00);
        message_q = '{8'h00};
        send_message(8'hFF);
        message_q = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h80, 8'h7F};
        send_message(8'hA5);
        drain_digests();

        // Random messages; the first one lands near the padding boundary
        while (items_sent < ITEM_TARGET)
        begin
            tx_burst = ($urandom_range(0, 3) == 0);
            if (messages_sent == 5 || $urandom_range(0, 15) == 0)
                len = $urandom_range(55, 64);
            else if ($urandom_range(0, 7) == 0)
                len = 0;
            else
                len = $urandom_range(1, 12);
            // keep the total close to the target
            if (len > ITEM_TARGET - items_sent - 1)
                len = ITEM_TARGET - items_sent - 1;
            fill_random(len);
            send_message(8'($urandom_range(0, 255)));
            if (messages_sent == 12)
                drain_digests();
        end
        s_axis_tvalid <= 1'b0;

        // Wind down
        drain_digests();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Covered %0d messages in %0d input items; %0d digest words compared.",
                 messages_sent, items_sent, words_checked);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Receiver: random stalls, quiet stretches, and one long hold-off
    initial
    begin
        int gap;
        int words_seen;
        bit rx_burst;
        bit held;
        words_seen = 0;
        rx_burst   = 1'b0;
        held       = 1'b0;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (words_seen % NUM_WORDS == 0)
                rx_burst = ($urandom_range(0, 3) == 0);
            gap = rx_burst ? 0 : $urandom_range(0, 11);
            if (!held && words_seen == HOLD_AT_WORD)
            begin
                gap  = LONG_HOLD;
                held = 1'b1;
            end
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
            words_seen++;
        end
    end

    // Watchdog: end the run if nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Timeout: no item moved for %0d cycles.", WATCHDOG_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

endmodule

FILE: sim.f
rtl/sha1h_pkg.sv
rtl/sha1h_ctrl.sv
rtl/sha1h_dp.sv
rtl/sha1_byte_stream_hasher.sv
dv/sha1_digest_checker.sv
dv/testbench.sv
